@@ rtl/stlcd_pkg.sv @@
`timescale 1ns / 1ps

package stlcd_pkg;

	// Widths of the channel fields
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned TYPE_W      = 4;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 64;

	// Number of length entries carried by one configuration register
	localparam int unsigned LENS_PER_REG = CFG_DATA_W / BYTE_W;

	// Framing constants
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
	// Two sync bytes summed modulo 256
	localparam logic [BYTE_W-1:0] SUM_SEED  = 8'hFE;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LEN_LO = 8'd0,
		REG_LEN_HI = 8'd1
	} cfg_reg_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_PAYLOAD = 2'd0,
		ST_SUM_OK  = 2'd1,
		ST_SUM_BAD = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	// Frame receiver phase, one-hot
	typedef enum logic [3:0] {
		PH_SYNC1 = 4'b0001,
		PH_SYNC2 = 4'b0010,
		PH_TYPE  = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [TYPE_W-1:0] packet_type;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] byte_index;
		logic              last;
		status_t           status;
	} result_t;

endpackage

@@ rtl/stlcd_if.sv @@
`timescale 1ns / 1ps

// Received byte stream
interface stlcd_rx_if;
	logic                             valid;
	logic                             ready;
	logic [stlcd_pkg::BYTE_W-1:0]     rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframed results
interface stlcd_res_if;
	logic                             valid;
	logic                             ready;
	logic [stlcd_pkg::TYPE_W-1:0]     packet_type;
	logic [stlcd_pkg::BYTE_W-1:0]     data_byte;
	logic [stlcd_pkg::BYTE_W-1:0]     byte_index;
	logic                             last;
	logic [stlcd_pkg::STATUS_W-1:0]   status;

	modport source (output valid, output packet_type, output data_byte,
		output byte_index, output last, output status, input ready);
	modport sink   (input valid, input packet_type, input data_byte,
		input byte_index, input last, input status, output ready);
endinterface

// Configuration writes
interface stlcd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [stlcd_pkg::CFG_INDEX_W-1:0]  index;
	logic [stlcd_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sync_type_length_checksum_deframer_core.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                                             Accepted when
// rx       in   rx_byte[7:0]                                        rx.valid & rx.ready
// res      out  packet_type[3:0] data_byte[7:0] byte_index[7:0]     res.valid & res.ready
//               last status[1:0]
// cfg      in   index[7:0] data[63:0]                               cfg.valid & cfg.ready
//
// One byte is taken per cycle while rx.ready is high. A byte sits in the input
// register while the frame state is updated, and its result, if any, is then
// written from there into the result register. Reset clears the frame state,
// the valid flags of both registers and the length table.
// rx.ready falls only when the result register is full and not being taken while
// the byte in the input register would produce another result. cfg is always ready.
module sync_type_length_checksum_deframer_core #(
	parameter int unsigned TYPE_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	stlcd_rx_if.sink           rx,
	stlcd_res_if.source        res,
	stlcd_cfg_if.sink          cfg
);

	// Width of an index into the length table.
	localparam int unsigned IDX_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

	// Per-type payload lengths; zero marks a type that is not known.
	logic [stlcd_pkg::BYTE_W-1:0] len_q [TYPE_COUNT];

	// Input register.
	logic                          vld_s1;
	logic [stlcd_pkg::BYTE_W-1:0]  byte_s1;

	// Frame state.
	stlcd_pkg::phase_t             phase_q;
	logic [stlcd_pkg::TYPE_W-1:0]  type_q;
	logic [stlcd_pkg::BYTE_W-1:0]  left_q;
	logic [stlcd_pkg::BYTE_W-1:0]  pos_q;
	logic [stlcd_pkg::BYTE_W-1:0]  sum_q;

	// Result register.
	logic                          out_vld_q;
	stlcd_pkg::result_t            out_q;

	// Next-state and result logic for the byte in the input register.
	stlcd_pkg::phase_t             phase_d;
	logic [stlcd_pkg::TYPE_W-1:0]  type_d;
	logic [stlcd_pkg::BYTE_W-1:0]  left_d;
	logic [stlcd_pkg::BYTE_W-1:0]  pos_d;
	logic [stlcd_pkg::BYTE_W-1:0]  sum_d;
	logic                          produce;
	stlcd_pkg::result_t            result;
	logic                          known;
	logic [stlcd_pkg::BYTE_W-1:0]  type_len;
	logic                          advance;

	// The configuration port never stalls.
	assign cfg.ready = 1'b1;

	// Entry e loads from byte lane e % 8 of REG_LEN_LO if e < 8, else of REG_LEN_HI.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < TYPE_COUNT; e++) begin
				len_q[e] <= '0;
			end
		end else if (cfg.valid) begin
			for (int e = 0; e < TYPE_COUNT; e++) begin
				if (cfg.index == ((e < stlcd_pkg::LENS_PER_REG) ?
						stlcd_pkg::REG_LEN_LO : stlcd_pkg::REG_LEN_HI)) begin
					len_q[e] <= cfg.data[(e % stlcd_pkg::LENS_PER_REG) * stlcd_pkg::BYTE_W
						+: stlcd_pkg::BYTE_W];
				end
			end
		end
	end

	// A type byte is known only if it lies inside the table and has a length.
	always_comb begin
		type_len = '0;
		if (byte_s1 < stlcd_pkg::BYTE_W'(TYPE_COUNT)) begin
			type_len = len_q[byte_s1[IDX_W-1:0]];
		end
		known = (type_len != '0);
	end

	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		left_d  = left_q;
		pos_d   = pos_q;
		sum_d   = sum_q;
		produce = 1'b0;
		result  = '{packet_type: type_q, data_byte: byte_s1, byte_index: pos_q,
			last: 1'b0, status: stlcd_pkg::ST_PAYLOAD};
		unique case (phase_q)
			stlcd_pkg::PH_SYNC1: begin
				phase_d = (byte_s1 == stlcd_pkg::SYNC_BYTE) ?
					stlcd_pkg::PH_SYNC2 : stlcd_pkg::PH_SYNC1;
			end
			stlcd_pkg::PH_SYNC2: begin
				phase_d = (byte_s1 == stlcd_pkg::SYNC_BYTE) ?
					stlcd_pkg::PH_TYPE : stlcd_pkg::PH_SYNC1;
			end
			stlcd_pkg::PH_TYPE: begin
				if (known) begin
					// A known type is below TYPE_COUNT, so for up to 16 types its low bits are the type.
					type_d  = byte_s1[stlcd_pkg::TYPE_W-1:0];
					left_d  = type_len;
					pos_d   = '0;
					sum_d   = stlcd_pkg::SUM_SEED + byte_s1;
					phase_d = stlcd_pkg::PH_BODY;
				end else begin
					// Rejected type: report it and go back to hunting for sync.
					produce            = 1'b1;
					result.packet_type = byte_s1[stlcd_pkg::TYPE_W-1:0];
					result.byte_index  = '0;
					result.last        = 1'b1;
					result.status      = stlcd_pkg::ST_UNKNOWN;
					phase_d            = stlcd_pkg::PH_SYNC1;
				end
			end
			stlcd_pkg::PH_BODY: begin
				produce = 1'b1;
				if (left_q != '0) begin
					sum_d  = sum_q + byte_s1;
					pos_d  = pos_q + 8'd1;
					left_d = left_q - 8'd1;
				end else begin
					// Checksum byte closes the frame.
					result.last   = 1'b1;
					result.status = (sum_q == byte_s1) ?
						stlcd_pkg::ST_SUM_OK : stlcd_pkg::ST_SUM_BAD;
					phase_d       = stlcd_pkg::PH_SYNC1;
				end
			end
			default: begin
				phase_d = stlcd_pkg::PH_SYNC1;
			end
		endcase
	end

	// The held byte moves on unless its result would overwrite one not yet taken.
	assign advance  = vld_s1 && (!produce || !out_vld_q || res.ready);
	assign rx.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stlcd_pkg::PH_SYNC1;
			type_q  <= '0;
			left_q  <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			left_q  <= left_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && produce) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_q <= result;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.packet_type = out_q.packet_type;
	assign res.data_byte   = out_q.data_byte;
	assign res.byte_index  = out_q.byte_index;
	assign res.last        = out_q.last;
	assign res.status      = out_q.status;

endmodule
